>>> hw/rtl/cerq_pkg.sv
// shared types, constants and ring helpers for the coalescing event ring queue
// no dependencies; used by cerq_ctrl, cerq_dpath and the top level

package cerq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_BITS    = 16;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int KIND_BITS   = 3;
   localparam int VALUE_BITS  = 16;
   localparam int CMD_BITS    = 2;

   typedef logic [PTR_BITS-1:0] ptr_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CREATE = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_ACK    = 2'd2,
      CMD_SIZE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_DECODE  = 3'd1,
      ST_SCAN    = 3'd2,
      ST_ADVANCE = 3'd3,
      ST_FINISH  = 3'd4
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic set_ok;
      logic ack_clear;
      logic scan_step;
      logic scan_commit;
      logic head_step;
      logic out_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    ack_in_range;
      logic    scan_end;
      logic    scan_hit;
      logic    head_stop;
   } dp_status_type;

   function automatic ptr_type ring_next(input ptr_type p);
      ptr_type r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   function automatic ptr_type ring_count(input ptr_type tail, input ptr_type head);
      logic [PTR_BITS:0] diff;
      diff = {1'b0, tail} - {1'b0, head};
      if (tail < head) begin
         diff = diff + (PTR_BITS+1)'(QUEUE_DEPTH);
      end
      return diff[PTR_BITS-1:0];
   endfunction

endpackage

>>> hw/rtl/coalescing_event_ring_queue_core.sv
// Coalescing event ring queue: 16 slots, one kept free. Commands are create (coalescing
// on key), find first pending of a kind, acknowledge slot, and read size; each item gives
// exactly one result. One item is in work at a time. Size and a rejected create go from
// decode straight to finish; create and find walk slots from the head until a match or the
// tail (up to 15 slots); acknowledge moves the head past slots no longer pending. The walk
// over the ring is the controller's scan loop, one slot a cycle. A finished result sits in an
// output register while the next item is taken.

module coalescing_event_ring_queue_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cerq_pkg::CMD_BITS-1:0]       req_cmd,
   input  logic [cerq_pkg::KIND_BITS-1:0]      req_event_kind,
   input  logic [cerq_pkg::KEY_BITS-1:0]       req_entry_key,
   input  logic [cerq_pkg::VALUE_BITS-1:0]     req_item_value,
   input  logic [cerq_pkg::PTR_BITS-1:0]       req_slot_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [cerq_pkg::PTR_BITS-1:0]       rsp_slot_out,
   output logic [cerq_pkg::KIND_BITS-1:0]      rsp_kind_out,
   output logic [cerq_pkg::KEY_BITS-1:0]       rsp_key_out,
   output logic [cerq_pkg::VALUE_BITS-1:0]     rsp_value_out,
   output logic [cerq_pkg::PTR_BITS-1:0]       rsp_occupancy,
   output logic                                rsp_signal_raised
);

   cerq_pkg::ctrl_cmd_type  ctrl;
   cerq_pkg::dp_status_type status;

   cerq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   cerq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_event_kind    (req_event_kind),
      .req_entry_key     (req_entry_key),
      .req_item_value    (req_item_value),
      .req_slot_index    (req_slot_index),
      .rsp_ok            (rsp_ok),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_kind_out      (rsp_kind_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_signal_raised (rsp_signal_raised)
   );

`ifndef SYNTHESIS
   // one item in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   // a raised signal only comes from a successful create, which reports no found entry
   a_signal_create: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_signal_raised |->
         rsp_ok && (rsp_kind_out == '0) && (rsp_key_out == '0) && (rsp_value_out == '0))
      else $error("signal raised on a result that is not a create");

   // a failed item reports no slot
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_slot_out == '0) && !rsp_signal_raised)
      else $error("failed result carries a slot or signal");

   // the scan never walks while a result is being handed over
   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> !ctrl.scan_step && !ctrl.head_step && !ctrl.scan_commit)
      else $error("datapath busy during result handover");
`endif

endmodule

>>> hw/rtl/cerq_ctrl.sv
// controller state machine of the coalescing event ring queue
// depends on cerq_pkg; drives cerq_dpath through ctrl_cmd_type

module cerq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cerq_pkg::dp_status_type status,
   output cerq_pkg::ctrl_cmd_type  ctrl
);

   cerq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == cerq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cerq_pkg::ST_IDLE: begin
            if (req_valid) state_in = cerq_pkg::ST_DECODE;
         end
         cerq_pkg::ST_DECODE: begin
            case (status.cmd)
               cerq_pkg::CMD_CREATE: begin
                  state_in = status.full ? cerq_pkg::ST_FINISH : cerq_pkg::ST_SCAN;
               end
               cerq_pkg::CMD_FIND: begin
                  state_in = cerq_pkg::ST_SCAN;
               end
               cerq_pkg::CMD_ACK: begin
                  state_in = status.ack_in_range ? cerq_pkg::ST_ADVANCE
                                                 : cerq_pkg::ST_FINISH;
               end
               default: begin
                  state_in = cerq_pkg::ST_FINISH;
               end
            endcase
         end
         cerq_pkg::ST_SCAN: begin
            if (status.scan_end || status.scan_hit) state_in = cerq_pkg::ST_FINISH;
         end
         cerq_pkg::ST_ADVANCE: begin
            if (status.head_stop) state_in = cerq_pkg::ST_FINISH;
         end
         cerq_pkg::ST_FINISH: begin
            if (out_free) state_in = cerq_pkg::ST_IDLE;
         end
         default: begin
            state_in = cerq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         cerq_pkg::ST_IDLE: begin
            ctrl.load = req_valid;
         end
         cerq_pkg::ST_DECODE: begin
            case (status.cmd)
               cerq_pkg::CMD_ACK: begin
                  ctrl.ack_clear = status.ack_in_range;
               end
               cerq_pkg::CMD_SIZE: begin
                  ctrl.set_ok = 1'b1;
               end
               default: begin
               end
            endcase
         end
         cerq_pkg::ST_SCAN: begin
            ctrl.scan_commit = status.scan_end || status.scan_hit;
            ctrl.scan_step   = !(status.scan_end || status.scan_hit);
         end
         cerq_pkg::ST_ADVANCE: begin
            ctrl.head_step = !status.head_stop;
         end
         cerq_pkg::ST_FINISH: begin
            ctrl.out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cerq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/cerq_dpath.sv
// datapath of the coalescing event ring queue: slot store, pointers, scan unit,
// result and output registers; depends on cerq_pkg, driven by cerq_ctrl

module cerq_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  cerq_pkg::ctrl_cmd_type              ctrl,
   output cerq_pkg::dp_status_type             status,
   input  logic [cerq_pkg::CMD_BITS-1:0]       req_cmd,
   input  logic [cerq_pkg::KIND_BITS-1:0]      req_event_kind,
   input  logic [cerq_pkg::KEY_BITS-1:0]       req_entry_key,
   input  logic [cerq_pkg::VALUE_BITS-1:0]     req_item_value,
   input  logic [cerq_pkg::PTR_BITS-1:0]       req_slot_index,
   output logic                                rsp_ok,
   output logic [cerq_pkg::PTR_BITS-1:0]       rsp_slot_out,
   output logic [cerq_pkg::KIND_BITS-1:0]      rsp_kind_out,
   output logic [cerq_pkg::KEY_BITS-1:0]       rsp_key_out,
   output logic [cerq_pkg::VALUE_BITS-1:0]     rsp_value_out,
   output logic [cerq_pkg::PTR_BITS-1:0]       rsp_occupancy,
   output logic                                rsp_signal_raised
);

   // latched request
   cerq_pkg::cmd_type                   cmd_ff;
   logic [cerq_pkg::KIND_BITS-1:0]      kind_ff;
   logic [cerq_pkg::KEY_BITS-1:0]       key_ff;
   logic [cerq_pkg::VALUE_BITS-1:0]     value_ff;
   logic [cerq_pkg::PTR_BITS-1:0]       sidx_ff;

   // slot store
   logic [cerq_pkg::KIND_BITS-1:0]      kind_mem  [cerq_pkg::QUEUE_DEPTH];
   logic [cerq_pkg::KEY_BITS-1:0]       key_mem   [cerq_pkg::QUEUE_DEPTH];
   logic [cerq_pkg::VALUE_BITS-1:0]     value_mem [cerq_pkg::QUEUE_DEPTH];

   logic [cerq_pkg::QUEUE_DEPTH-1:0]    pending_ff, pending_in;
   cerq_pkg::ptr_type                   head_ff, head_in;
   cerq_pkg::ptr_type                   tail_ff, tail_in;
   cerq_pkg::ptr_type                   scan_ff, scan_in;

   // result being built
   logic                                res_ok_ff, res_ok_in;
   cerq_pkg::ptr_type                   res_slot_ff, res_slot_in;
   logic [cerq_pkg::KIND_BITS-1:0]      res_kind_ff, res_kind_in;
   logic [cerq_pkg::KEY_BITS-1:0]       res_key_ff, res_key_in;
   logic [cerq_pkg::VALUE_BITS-1:0]     res_value_ff, res_value_in;
   logic                                res_sig_ff, res_sig_in;

   // output register
   logic                                out_ok_ff;
   cerq_pkg::ptr_type                   out_slot_ff;
   logic [cerq_pkg::KIND_BITS-1:0]      out_kind_ff;
   logic [cerq_pkg::KEY_BITS-1:0]       out_key_ff;
   logic [cerq_pkg::VALUE_BITS-1:0]     out_value_ff;
   cerq_pkg::ptr_type                   out_occ_ff;
   logic                                out_sig_ff;

   logic [cerq_pkg::KIND_BITS-1:0]      rd_kind_ff;
   logic [cerq_pkg::KEY_BITS-1:0]       rd_key_ff;
   logic [cerq_pkg::VALUE_BITS-1:0]     rd_value_ff;
   logic                                scan_end;
   logic                                scan_hit;
   logic                                write_en;
   cerq_pkg::ptr_type                   write_addr;

   // create coalesces on key, find matches on kind
   assign scan_end = (scan_ff == tail_ff);
   assign scan_hit = !scan_end && pending_ff[scan_ff] &&
                     ((cmd_ff == cerq_pkg::CMD_CREATE) ? (rd_key_ff == key_ff)
                                                       : (rd_kind_ff == kind_ff));

   assign write_en   = ctrl.scan_commit && (cmd_ff == cerq_pkg::CMD_CREATE);
   assign write_addr = scan_hit ? scan_ff : tail_ff;

   always_comb begin
      status.cmd          = cmd_ff;
      status.full         = (cerq_pkg::ring_next(tail_ff) == head_ff);
      status.ack_in_range = ({1'b0, sidx_ff} < (cerq_pkg::PTR_BITS+1)'(cerq_pkg::QUEUE_DEPTH));
      status.scan_end     = scan_end;
      status.scan_hit     = scan_hit;
      status.head_stop    = (head_ff == tail_ff) || pending_ff[head_ff];
   end

   always_comb begin
      pending_in = pending_ff;
      if (write_en) pending_in[write_addr] = 1'b1;
      if (ctrl.ack_clear) pending_in[sidx_ff] = 1'b0;

      tail_in = tail_ff;
      if (write_en && !scan_hit) tail_in = cerq_pkg::ring_next(tail_ff);

      head_in = ctrl.head_step ? cerq_pkg::ring_next(head_ff) : head_ff;

      scan_in = scan_ff;
      if (ctrl.load) begin
         scan_in = head_ff;
      end else if (ctrl.scan_step) begin
         scan_in = cerq_pkg::ring_next(scan_ff);
      end
   end

   always_comb begin
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      res_kind_in  = res_kind_ff;
      res_key_in   = res_key_ff;
      res_value_in = res_value_ff;
      res_sig_in   = res_sig_ff;
      if (ctrl.load) begin
         res_ok_in    = 1'b0;
         res_slot_in  = '0;
         res_kind_in  = '0;
         res_key_in   = '0;
         res_value_in = '0;
         res_sig_in   = 1'b0;
      end else if (ctrl.set_ok || ctrl.ack_clear) begin
         res_ok_in = 1'b1;
      end else if (write_en) begin
         res_ok_in   = 1'b1;
         res_sig_in  = 1'b1;
         res_slot_in = write_addr;
      end else if (ctrl.scan_commit && scan_hit) begin
         res_ok_in    = 1'b1;
         res_slot_in  = scan_ff;
         res_kind_in  = rd_kind_ff;
         res_key_in   = rd_key_ff;
         res_value_in = rd_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff   <= cerq_pkg::cmd_type'(req_cmd);
         kind_ff  <= req_event_kind;
         key_ff   <= req_entry_key;
         value_ff <= req_item_value;
         sidx_ff  <= req_slot_index;
      end
      if (write_en) begin
         kind_mem[write_addr]  <= kind_ff;
         key_mem[write_addr]   <= key_ff;
         value_mem[write_addr] <= value_ff;
      end
      // read port follows the next scan slot so the data lines up with scan_ff
      rd_kind_ff   <= kind_mem[scan_in];
      rd_key_ff    <= key_mem[scan_in];
      rd_value_ff  <= value_mem[scan_in];
      scan_ff      <= scan_in;
      res_ok_ff    <= res_ok_in;
      res_slot_ff  <= res_slot_in;
      res_kind_ff  <= res_kind_in;
      res_key_ff   <= res_key_in;
      res_value_ff <= res_value_in;
      res_sig_ff   <= res_sig_in;
      // pointers are final by the time the result is handed over
      if (ctrl.out_load) begin
         out_ok_ff    <= res_ok_ff;
         out_slot_ff  <= res_slot_ff;
         out_kind_ff  <= res_kind_ff;
         out_key_ff   <= res_key_ff;
         out_value_ff <= res_value_ff;
         out_occ_ff   <= cerq_pkg::ring_count(tail_ff, head_ff);
         out_sig_ff   <= res_sig_ff;
      end
   end

   assign rsp_ok            = out_ok_ff;
   assign rsp_slot_out      = out_slot_ff;
   assign rsp_kind_out      = out_kind_ff;
   assign rsp_key_out       = out_key_ff;
   assign rsp_value_out     = out_value_ff;
   assign rsp_occupancy     = out_occ_ff;
   assign rsp_signal_raised = out_sig_ff;

endmodule

>>> test/coalescing_event_ring_queue_checker.sv
`timescale 1ns / 1ps
// scoreboard for the coalescing event ring queue: mirrors the ring on each accepted item
// and checks every result in order; depends on cerq_pkg for widths and command codes

module coalescing_event_ring_queue_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [cerq_pkg::CMD_BITS-1:0]   req_cmd,
   input  logic [cerq_pkg::KIND_BITS-1:0]  req_event_kind,
   input  logic [cerq_pkg::KEY_BITS-1:0]   req_entry_key,
   input  logic [cerq_pkg::VALUE_BITS-1:0] req_item_value,
   input  cerq_pkg::ptr_type               req_slot_index,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_ok,
   input  cerq_pkg::ptr_type               rsp_slot_out,
   input  logic [cerq_pkg::KIND_BITS-1:0]  rsp_kind_out,
   input  logic [cerq_pkg::KEY_BITS-1:0]   rsp_key_out,
   input  logic [cerq_pkg::VALUE_BITS-1:0] rsp_value_out,
   input  cerq_pkg::ptr_type               rsp_occupancy,
   input  logic                            rsp_signal_raised,
   output int                              mismatches,
   output int                              awaited,
   output int                              replies_seen,
   output int                              merges,
   output int                              refusals,
   output int                              find_hits
);

   typedef struct packed {
      logic                            ok;
      cerq_pkg::ptr_type               slot;
      logic [cerq_pkg::KIND_BITS-1:0]  kind;
      logic [cerq_pkg::KEY_BITS-1:0]   key;
      logic [cerq_pkg::VALUE_BITS-1:0] value;
      cerq_pkg::ptr_type               occupancy;
      logic                            raised;
   } ring_reply_type;

   logic [cerq_pkg::KIND_BITS-1:0]  mirror_kind    [cerq_pkg::QUEUE_DEPTH];
   logic [cerq_pkg::KEY_BITS-1:0]   mirror_key     [cerq_pkg::QUEUE_DEPTH];
   logic [cerq_pkg::VALUE_BITS-1:0] mirror_value   [cerq_pkg::QUEUE_DEPTH];
   logic                            mirror_pending [cerq_pkg::QUEUE_DEPTH];
   int                              head_pos;
   int                              tail_pos;
   ring_reply_type                  awaited_replies[$];

   function automatic int wrap_next(input int p);
      return (p + 1) % cerq_pkg::QUEUE_DEPTH;
   endfunction

   // applies one item to the mirrored ring and returns the result it should produce
   function automatic ring_reply_type predict_ring_reply(
         input cerq_pkg::cmd_type               c,
         input logic [cerq_pkg::KIND_BITS-1:0]  kind,
         input logic [cerq_pkg::KEY_BITS-1:0]   key,
         input logic [cerq_pkg::VALUE_BITS-1:0] value,
         input cerq_pkg::ptr_type               idx);
      ring_reply_type r;
      int             p;
      int             nt;
      logic           hit;
      r   = '0;
      hit = 1'b0;
      case (c)
         cerq_pkg::CMD_CREATE: begin
            nt = wrap_next(tail_pos);
            if (nt != head_pos) begin
               p = head_pos;
               while (p != tail_pos && !hit) begin
                  if (mirror_pending[p] && mirror_key[p] == key) begin
                     hit = 1'b1;
                  end else begin
                     p = wrap_next(p);
                  end
               end
               if (hit) begin
                  merges++;
               end else begin
                  p        = tail_pos;
                  tail_pos = nt;
               end
               mirror_kind[p]    = kind;
               mirror_key[p]     = key;
               mirror_value[p]   = value;
               mirror_pending[p] = 1'b1;
               r.ok     = 1'b1;
               r.raised = 1'b1;
               r.slot   = cerq_pkg::ptr_type'(p);
            end else begin
               refusals++;
            end
         end
         cerq_pkg::CMD_FIND: begin
            p = head_pos;
            while (p != tail_pos && !hit) begin
               if (mirror_pending[p] && mirror_kind[p] == kind) begin
                  hit     = 1'b1;
                  r.ok    = 1'b1;
                  r.slot  = cerq_pkg::ptr_type'(p);
                  r.kind  = mirror_kind[p];
                  r.key   = mirror_key[p];
                  r.value = mirror_value[p];
                  find_hits++;
               end else begin
                  p = wrap_next(p);
               end
            end
         end
         cerq_pkg::CMD_ACK: begin
            if (int'(idx) < cerq_pkg::QUEUE_DEPTH) begin
               mirror_pending[idx] = 1'b0;
               while (head_pos != tail_pos && !mirror_pending[head_pos]) begin
                  head_pos = wrap_next(head_pos);
               end
               r.ok = 1'b1;
            end
         end
         default: begin
            r.ok = 1'b1;
         end
      endcase
      r.occupancy = cerq_pkg::ptr_type'((tail_pos + cerq_pkg::QUEUE_DEPTH - head_pos)
                                        % cerq_pkg::QUEUE_DEPTH);
      return r;
   endfunction

   always @(posedge clock) begin
      ring_reply_type exp;
      ring_reply_type got;
      if (reset) begin
         for (int i = 0; i < cerq_pkg::QUEUE_DEPTH; i++) begin
            mirror_pending[i] = 1'b0;
            mirror_kind[i]    = '0;
            mirror_key[i]     = '0;
            mirror_value[i]   = '0;
         end
         head_pos = 0;
         tail_pos = 0;
         awaited_replies.delete();
         mismatches   = 0;
         replies_seen = 0;
         merges       = 0;
         refusals     = 0;
         find_hits    = 0;
      end else begin
         // a result never belongs to the item taken at the same edge, so pop first
         if (rsp_valid && rsp_ready) begin
            got.ok        = rsp_ok;
            got.slot      = rsp_slot_out;
            got.kind      = rsp_kind_out;
            got.key       = rsp_key_out;
            got.value     = rsp_value_out;
            got.occupancy = rsp_occupancy;
            got.raised    = rsp_signal_raised;
            if (awaited_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result with nothing outstanding: ok %0b slot %0d occ %0d",
                           got.ok, got.slot, got.occupancy);
               end
            end else begin
               exp = awaited_replies.pop_front();
               if (got !== exp) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("result %0d mismatch (exp/act): ok %0b/%0b slot %0d/%0d ",
                            replies_seen, exp.ok, got.ok, exp.slot, got.slot);
                     $display("kind %0d/%0d key %h/%h value %h/%h occ %0d/%0d sig %0b/%0b",
                              exp.kind, got.kind, exp.key, got.key, exp.value, got.value,
                              exp.occupancy, got.occupancy, exp.raised, got.raised);
                  end
               end
            end
            replies_seen++;
         end
         if (req_valid && req_ready) begin
            awaited_replies.push_back(predict_ring_reply(cerq_pkg::cmd_type'(req_cmd),
                                                         req_event_kind, req_entry_key,
                                                         req_item_value, req_slot_index));
         end
      end
      awaited = awaited_replies.size();
   end

endmodule

>>> test/coalescing_event_ring_queue_core_tb.sv
`timescale 1ns / 1ps
// top of the coalescing event ring queue test: drives items with random gaps and a long
// result stall; depends on cerq_pkg, the core and coalescing_event_ring_queue_checker

module coalescing_event_ring_queue_core_tb;
   import cerq_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 400;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} traffic_mix_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CMD_BITS-1:0]   req_cmd;
   logic [KIND_BITS-1:0]  req_event_kind;
   logic [KEY_BITS-1:0]   req_entry_key;
   logic [VALUE_BITS-1:0] req_item_value;
   ptr_type               req_slot_index;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_ok;
   ptr_type               rsp_slot_out;
   logic [KIND_BITS-1:0]  rsp_kind_out;
   logic [KEY_BITS-1:0]   rsp_key_out;
   logic [VALUE_BITS-1:0] rsp_value_out;
   ptr_type               rsp_occupancy;
   logic                  rsp_signal_raised;

   int   mismatches;
   int   awaited;
   int   replies_seen;
   int   merges;
   int   refusals;
   int   find_hits;
   int   items_sent;
   int   cycle_count = 0;
   logic sender_burst;

   always #6 clock = ~clock;

   coalescing_event_ring_queue_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_event_kind    (req_event_kind),
      .req_entry_key     (req_entry_key),
      .req_item_value    (req_item_value),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_kind_out      (rsp_kind_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_signal_raised (rsp_signal_raised)
   );

   coalescing_event_ring_queue_checker ring_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_event_kind    (req_event_kind),
      .req_entry_key     (req_entry_key),
      .req_item_value    (req_item_value),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_kind_out      (rsp_kind_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_signal_raised (rsp_signal_raised),
      .mismatches        (mismatches),
      .awaited           (awaited),
      .replies_seen      (replies_seen),
      .merges            (merges),
      .refusals          (refusals),
      .find_hits         (find_hits)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic offer_item(input cmd_type c, input logic [KIND_BITS-1:0] kind,
                             input logic [KEY_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] value, input ptr_type idx);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_cmd        <= c;
      req_event_kind <= kind;
      req_entry_key  <= key;
      req_item_value <= value;
      req_slot_index <= idx;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // result side: per-item gaps, zero-gap stretches, one long hold that backs up the ring
   initial begin
      int   gap;
      int   taken;
      logic burst;
      rsp_ready = 1'b0;
      taken     = 0;
      burst     = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 40 == 0) begin
            burst = ($urandom_range(0, 2) == 0);
         end
         if (taken == 120) begin
            gap = LONG_HOLD;
         end else begin
            gap = burst ? 0 : $urandom_range(0, 5);
         end
         if (gap > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      int                    n;
      int                    roll;
      traffic_mix_t          mix;
      cmd_type               c;
      logic [KIND_BITS-1:0]  kind;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      ptr_type               idx;
      ptr_type               ack_cursor;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_SIZE;
      req_event_kind = '0;
      req_entry_key  = '0;
      req_item_value = '0;
      req_slot_index = '0;
      sender_burst   = 1'b0;
      items_sent     = 0;
      ack_cursor     = '0;
      mix            = MIX_BLEND;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty ring: size, find with no match, acknowledge of a slot that is not pending
      offer_item(CMD_SIZE, 3'd0, 16'h0000, 16'h0000, 4'd0);
      offer_item(CMD_FIND, 3'd5, 16'h0000, 16'h0000, 4'd0);
      offer_item(CMD_ACK, 3'd0, 16'h0000, 16'h0000, 4'd0);
      // field extremes, then a key match that rewrites kind and value in place
      offer_item(CMD_CREATE, 3'd0, 16'h0000, 16'h0000, 4'd0);
      offer_item(CMD_CREATE, 3'd7, 16'hFFFF, 16'hFFFF, 4'd15);
      offer_item(CMD_CREATE, 3'd3, 16'hFFFF, 16'h1234, 4'd0);
      offer_item(CMD_FIND, 3'd7, 16'hFFFF, 16'hFFFF, 4'd15);
      offer_item(CMD_FIND, 3'd3, 16'h0000, 16'h0000, 4'd0);
      // acknowledge behind a pending head, then the head itself
      offer_item(CMD_ACK, 3'd0, 16'h0000, 16'h0000, 4'd1);
      offer_item(CMD_ACK, 3'd7, 16'hFFFF, 16'hFFFF, 4'd0);
      // fill to capacity, then a create on a pending key while full
      for (n = 0; n < QUEUE_DEPTH - 1; n++) begin
         offer_item(CMD_CREATE, KIND_BITS'(n), KEY_BITS'(16'h1000 + n),
                    VALUE_BITS'(n * 16'h1111), 4'd0);
      end
      offer_item(CMD_CREATE, 3'd6, 16'h1003, 16'hBEEF, 4'd0);
      offer_item(CMD_SIZE, 3'd7, 16'hFFFF, 16'hFFFF, 4'd15);
      offer_item(CMD_ACK, 3'd0, 16'h0000, 16'h0000, 4'd15);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) begin
            mix          = traffic_mix_t'($urandom_range(0, 2));
            sender_burst = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         case (mix)
            MIX_FILL: begin
               c = (roll < 65) ? CMD_CREATE : (roll < 80) ? CMD_FIND :
                   (roll < 90) ? CMD_ACK : CMD_SIZE;
            end
            MIX_DRAIN: begin
               c = (roll < 20) ? CMD_CREATE : (roll < 35) ? CMD_FIND :
                   (roll < 90) ? CMD_ACK : CMD_SIZE;
            end
            default: begin
               c = (roll < 35) ? CMD_CREATE : (roll < 60) ? CMD_FIND :
                   (roll < 90) ? CMD_ACK : CMD_SIZE;
            end
         endcase
         kind  = KIND_BITS'($urandom_range(0, 7));
         value = VALUE_BITS'($urandom);
         // mostly a small key pool so creates coalesce, the rest anywhere in the key space
         if ($urandom_range(0, 9) < 7) begin
            key = KEY_BITS'($urandom_range(0, 19) * 3329);
         end else begin
            key = KEY_BITS'($urandom);
         end
         // sweeping acknowledges walk the ring so the head keeps moving
         if (c == CMD_ACK && mix == MIX_DRAIN && $urandom_range(0, 9) < 7) begin
            idx        = ack_cursor;
            ack_cursor = ack_cursor + 1'b1;
         end else begin
            idx = ptr_type'($urandom_range(0, QUEUE_DEPTH - 1));
         end
         offer_item(c, kind, key, value, idx);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (awaited != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("run covered %0d items and checked %0d results, %0d mismatches",
               items_sent, replies_seen, mismatches);
      $display("creates merged on key %0d, creates refused on a full ring %0d, finds matched %0d",
               merges, refusals, find_hits);
      if (mismatches == 0 && awaited == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> coalescing_event_ring_queue_core.f
hw/rtl/cerq_pkg.sv
hw/rtl/cerq_ctrl.sv
hw/rtl/cerq_dpath.sv
hw/rtl/coalescing_event_ring_queue_core.sv
test/coalescing_event_ring_queue_checker.sv
test/coalescing_event_ring_queue_core_tb.sv
